### rtl/core/h3b_pkg.sv
// ----------------------------------------------------------------------------
// h3b_pkg
// Shared types, constants and helpers for the 3D histogram binner.
// ----------------------------------------------------------------------------
package h3b_pkg;

    localparam int MAX_X_BINS  = 32;
    localparam int MAX_Y_BINS  = 32;
    localparam int MAX_Z_BINS  = 32;
    localparam int COUNT_WIDTH = 32;

    localparam int STORE_DEPTH = MAX_X_BINS * MAX_Y_BINS * MAX_Z_BINS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int MAX_XY_BINS  = (MAX_X_BINS > MAX_Y_BINS) ? MAX_X_BINS : MAX_Y_BINS;
    localparam int MAX_ALL_BINS = (MAX_XY_BINS > MAX_Z_BINS) ? MAX_XY_BINS : MAX_Z_BINS;
    localparam int IDX_W        = (MAX_ALL_BINS > 1) ? $clog2(MAX_ALL_BINS) : 1;

    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0][5:0] AXIS_MAX = {6'(MAX_Z_BINS), 6'(MAX_Y_BINS), 6'(MAX_X_BINS)};

    localparam logic [30:0] WIDTH_RST  = 31'd65536;
    localparam logic [17:0] COUNTS_RST = 18'd133152;

    typedef enum logic [1:0] {
        CMD_BIN   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_BINNED = 2'd0,
        STAT_MISSED = 2'd1,
        STAT_DONE   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_X_MIN      = 3'd0,
        CFG_Y_MIN      = 3'd1,
        CFG_Z_MIN      = 3'd2,
        CFG_X_WIDTH    = 3'd3,
        CFG_Y_WIDTH    = 3'd4,
        CFG_Z_WIDTH    = 3'd5,
        CFG_BIN_COUNTS = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_HIT,
        OP_MISS,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [2:0][31:0] axis_min;
        logic [2:0][30:0] axis_width;
        logic [2:0][5:0]  axis_count;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [31:0] to_word(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

    function automatic logic [ADDR_W-1:0] bin_addr(input logic [IDX_W-1:0] xi,
                                                   input logic [IDX_W-1:0] yi,
                                                   input logic [IDX_W-1:0] zi);
        return ADDR_W'((32'(xi) * 32'(MAX_Y_BINS) + 32'(yi)) * 32'(MAX_Z_BINS) + 32'(zi));
    endfunction

endpackage

### rtl/core/h3b_fifo.sv
// ----------------------------------------------------------------------------
// h3b_fifo
// Short queue of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module h3b_fifo
    import h3b_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_i,
    input  entry_t push_data_i,
    output logic   full_o,
    input  logic   pop_i,
    output entry_t head_o,
    output logic   empty_o
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    entry_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full_o  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty_o = (count_reg == '0);
    assign head_o  = mem_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data_i;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_i |-> !empty_o)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/core/h3b_front.sv
// ----------------------------------------------------------------------------
// h3b_front
// Accepts words, computes per-axis bin indices with a shared restoring
// divider (one quotient bit per cycle), and queues the resulting operation.
// ----------------------------------------------------------------------------
module h3b_front
    import h3b_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg_i,
    input  logic               init_busy_i,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_x_coord,
    input  logic signed [31:0] s_y_coord,
    input  logic signed [31:0] s_z_coord,
    input  logic [4:0]         s_read_x_index,
    input  logic [4:0]         s_read_y_index,
    input  logic [4:0]         s_read_z_index,
    output logic               push_o,
    output entry_t             entry_o,
    input  logic               full_i
);

    localparam int DIV_W  = 31 + IDX_W;
    localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SETUP,
        F_DIV,
        F_CHK,
        F_PUSH
    } fstate_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    fstate_t           state_reg, state_next;
    axis_t             axis_reg, axis_next;
    logic [2:0][31:0]  coord_reg, coord_next;
    logic [31:0]       rem_reg, rem_next;
    logic [IDX_W-1:0]  q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  xi_reg, xi_next;
    logic [IDX_W-1:0]  yi_reg, yi_next;
    entry_t            entry_reg, entry_next;

    logic [31:0]       coord_sel;
    logic [31:0]       min_sel;
    logic [30:0]       width_sel;
    logic [5:0]        count_sel;
    logic [5:0]        max_sel;
    logic [5:0]        n_sel;
    logic [32:0]       diff;
    logic              ovf;
    logic [DIV_W-1:0]  shifted;
    logic [DIV_W-1:0]  rem_ext;
    logic [DIV_W-1:0]  rem_sub;
    logic              rd_in_range;

    assign s_ready = (state_reg == F_IDLE) && !init_busy_i;
    assign push_o  = (state_reg == F_PUSH) && !full_i;
    assign entry_o = entry_reg;

    always_comb begin
        coord_sel = coord_reg[axis_reg];
        min_sel   = cfg_i.axis_min[axis_reg];
        width_sel = cfg_i.axis_width[axis_reg];
        count_sel = cfg_i.axis_count[axis_reg];
        max_sel   = AXIS_MAX[axis_reg];
        n_sel     = (count_sel > max_sel) ? max_sel : count_sel;
        diff      = {coord_sel[31], coord_sel} - {min_sel[31], min_sel};
        ovf       = (diff[31:0] >> IDX_W) >= {1'b0, width_sel};
        shifted   = DIV_W'(width_sel) << step_reg;
        rem_ext   = DIV_W'(rem_reg);
        rem_sub   = rem_ext - shifted;
        rd_in_range = ({1'b0, s_read_x_index} < AXIS_MAX[0])
                   && ({1'b0, s_read_y_index} < AXIS_MAX[1])
                   && ({1'b0, s_read_z_index} < AXIS_MAX[2]);
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        coord_next = coord_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        xi_next    = xi_reg;
        yi_next    = yi_reg;
        entry_next = entry_reg;

        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    coord_next = {s_z_coord, s_y_coord, s_x_coord};
                    axis_next  = AX_X;
                    entry_next.addr = bin_addr(IDX_W'(s_read_x_index),
                                               IDX_W'(s_read_y_index),
                                               IDX_W'(s_read_z_index));
                    case (cmd_t'(s_cmd))
                        CMD_BIN: begin
                            state_next = F_SETUP;
                        end
                        CMD_CLEAR: begin
                            entry_next.op = OP_CLEAR;
                            state_next    = F_PUSH;
                        end
                        CMD_READ: begin
                            entry_next.op = rd_in_range ? OP_READ : OP_NOP;
                            state_next    = F_PUSH;
                        end
                        default: begin
                            entry_next.op = OP_NOP;
                            state_next    = F_PUSH;
                        end
                    endcase
                end
            end
            F_SETUP: begin
                if (diff[32] || (width_sel == '0) || ovf) begin
                    entry_next.op = OP_MISS;
                    state_next    = F_PUSH;
                end else begin
                    rem_next   = diff[31:0];
                    q_next     = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (rem_ext >= shifted) begin
                    rem_next = rem_sub[31:0];
                    q_next   = q_reg | (IDX_W'(1) << step_reg);
                end
                if (step_reg == '0) begin
                    state_next = F_CHK;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            F_CHK: begin
                if (6'(q_reg) < n_sel) begin
                    case (axis_reg)
                        AX_X: begin
                            xi_next    = q_reg;
                            axis_next  = AX_Y;
                            state_next = F_SETUP;
                        end
                        AX_Y: begin
                            yi_next    = q_reg;
                            axis_next  = AX_Z;
                            state_next = F_SETUP;
                        end
                        default: begin
                            entry_next.op   = OP_HIT;
                            entry_next.addr = bin_addr(xi_reg, yi_reg, q_reg);
                            state_next      = F_PUSH;
                        end
                    endcase
                end else begin
                    entry_next.op = OP_MISS;
                    state_next    = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!full_i) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            axis_reg  <= AX_X;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
        coord_reg <= coord_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        step_reg  <= step_next;
        xi_reg    <= xi_next;
        yi_reg    <= yi_next;
        entry_reg <= entry_next;
    end

endmodule

### rtl/core/h3b_back.sv
// ----------------------------------------------------------------------------
// h3b_back
// Executes queued operations: bin read-modify-write, totals, clear sweep,
// and the registered result port.
// ----------------------------------------------------------------------------
module h3b_back
    import h3b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  entry_t      head_i,
    input  logic        empty_i,
    output logic        pop_o,
    output logic        init_busy_o,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_bin_value,
    output logic [31:0] m_binned_total,
    output logic [31:0] m_missed_total
);

    typedef enum logic [1:0] {
        B_INIT,
        B_IDLE,
        B_UPD,
        B_CLR
    } bstate_t;

    logic [COUNT_WIDTH-1:0] mem [STORE_DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    bstate_t                state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [COUNT_WIDTH-1:0] bin_tot_reg, bin_tot_next;
    logic [COUNT_WIDTH-1:0] miss_tot_reg, miss_tot_next;
    logic                   valid_reg, valid_next;
    status_t                status_reg, status_next;
    logic [31:0]            value_reg, value_next;
    logic [31:0]            bin_out_reg, bin_out_next;
    logic [31:0]            miss_out_reg, miss_out_next;

    logic                   out_free;
    logic                   clr_last;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] bin_inc;

    assign out_free       = !valid_reg || m_ready;
    assign clr_last       = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
    assign bin_inc        = sat_inc(rd_data_reg);
    assign init_busy_o    = (state_reg == B_INIT);
    assign m_valid        = valid_reg;
    assign m_status       = status_reg;
    assign m_bin_value    = value_reg;
    assign m_binned_total = bin_out_reg;
    assign m_missed_total = miss_out_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        clr_cnt_next  = clr_cnt_reg;
        bin_tot_next  = bin_tot_reg;
        miss_tot_next = miss_tot_reg;
        valid_next    = valid_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        bin_out_next  = bin_out_reg;
        miss_out_next = miss_out_reg;
        pop_o         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = '0;

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            B_INIT: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_last) begin
                    clr_cnt_next = '0;
                    state_next   = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!empty_i && out_free) begin
                    pop_o     = 1'b1;
                    op_next   = head_i.op;
                    addr_next = head_i.addr;
                    case (head_i.op)
                        OP_HIT, OP_READ: begin
                            state_next = B_UPD;
                        end
                        OP_MISS: begin
                            miss_tot_next = sat_inc(miss_tot_reg);
                            valid_next    = 1'b1;
                            status_next   = STAT_MISSED;
                            value_next    = '0;
                            bin_out_next  = to_word(bin_tot_reg);
                            miss_out_next = to_word(sat_inc(miss_tot_reg));
                        end
                        OP_CLEAR: begin
                            bin_tot_next  = '0;
                            miss_tot_next = '0;
                            clr_cnt_next  = '0;
                            state_next    = B_CLR;
                        end
                        default: begin
                            valid_next    = 1'b1;
                            status_next   = STAT_DONE;
                            value_next    = '0;
                            bin_out_next  = to_word(bin_tot_reg);
                            miss_out_next = to_word(miss_tot_reg);
                        end
                    endcase
                end
            end
            B_UPD: begin
                valid_next    = 1'b1;
                miss_out_next = to_word(miss_tot_reg);
                if (op_reg == OP_HIT) begin
                    mem_we       = 1'b1;
                    mem_wdata    = bin_inc;
                    bin_tot_next = sat_inc(bin_tot_reg);
                    status_next  = STAT_BINNED;
                    value_next   = to_word(bin_inc);
                    bin_out_next = to_word(sat_inc(bin_tot_reg));
                end else begin
                    status_next  = STAT_DONE;
                    value_next   = to_word(rd_data_reg);
                    bin_out_next = to_word(bin_tot_reg);
                end
                state_next = B_IDLE;
            end
            B_CLR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_last) begin
                    clr_cnt_next  = '0;
                    valid_next    = 1'b1;
                    status_next   = STAT_DONE;
                    value_next    = '0;
                    bin_out_next  = '0;
                    miss_out_next = '0;
                    state_next    = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_INIT;
            clr_cnt_reg  <= '0;
            bin_tot_reg  <= '0;
            miss_tot_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            bin_tot_reg  <= bin_tot_next;
            miss_tot_reg <= miss_tot_next;
            valid_reg    <= valid_next;
        end
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        bin_out_reg  <= bin_out_next;
        miss_out_reg <= miss_out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[head_i.addr];
    end

    a_upd_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_UPD) |-> !valid_reg)
        else $error("result register busy at bin update");

endmodule

### rtl/core/histogram_3d_binner.sv
// ----------------------------------------------------------------------------
// histogram_3d_binner
// 3D histogram of signed Q16.16 points over a 32x32x32 bin store.
//
//  channel   direction  handshake           word
//  cfg       in         cfg_valid/ready     cfg_index, cfg_data
//  s         in         s_valid/s_ready     cmd, coords, read indices
//  m         out        m_valid/m_ready     status, bin value, totals
//
//  Point: the front end runs the per-axis divider (IDX_W quotient bits,
//  one per cycle, axes x, y, z in turn); the back end then reads and updates the bin.
//  Clear: a sweep over the whole store, one bin zeroed per cycle.
//  Reset: a sweep zeroes the store; s_ready stays low while it runs.
//  A two-word queue lets the front work on the next word while the back
//  end or the result register waits on m_ready.
// ----------------------------------------------------------------------------
module histogram_3d_binner
    import h3b_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_x_coord,
    input  logic signed [31:0] s_y_coord,
    input  logic signed [31:0] s_z_coord,
    input  logic [4:0]         s_read_x_index,
    input  logic [4:0]         s_read_y_index,
    input  logic [4:0]         s_read_z_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_bin_value,
    output logic [31:0]        m_binned_total,
    output logic [31:0]        m_missed_total
);

    cfg_t   cfg_reg, cfg_next;
    logic   init_busy;
    logic   push;
    entry_t push_data;
    logic   full;
    logic   pop;
    entry_t head;
    logic   empty;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_X_MIN:      cfg_next.axis_min[0]   = cfg_data;
                CFG_Y_MIN:      cfg_next.axis_min[1]   = cfg_data;
                CFG_Z_MIN:      cfg_next.axis_min[2]   = cfg_data;
                CFG_X_WIDTH:    cfg_next.axis_width[0] = cfg_data[30:0];
                CFG_Y_WIDTH:    cfg_next.axis_width[1] = cfg_data[30:0];
                CFG_Z_WIDTH:    cfg_next.axis_width[2] = cfg_data[30:0];
                CFG_BIN_COUNTS: cfg_next.axis_count    = cfg_data[17:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_min   <= '0;
            cfg_reg.axis_width <= {WIDTH_RST, WIDTH_RST, WIDTH_RST};
            cfg_reg.axis_count <= COUNTS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    h3b_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_i          (cfg_reg),
        .init_busy_i    (init_busy),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_x_coord      (s_x_coord),
        .s_y_coord      (s_y_coord),
        .s_z_coord      (s_z_coord),
        .s_read_x_index (s_read_x_index),
        .s_read_y_index (s_read_y_index),
        .s_read_z_index (s_read_z_index),
        .push_o         (push),
        .entry_o        (push_data),
        .full_i         (full)
    );

    h3b_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .push_data_i (push_data),
        .full_o      (full),
        .pop_i       (pop),
        .head_o      (head),
        .empty_o     (empty)
    );

    h3b_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_i         (head),
        .empty_i        (empty),
        .pop_o          (pop),
        .init_busy_o    (init_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bin_value    (m_bin_value),
        .m_binned_total (m_binned_total),
        .m_missed_total (m_missed_total)
    );

endmodule

### test/histogram_3d_binner_test.sv
// ----------------------------------------------------------------------------
// histogram_3d_binner_test
// Sends points, clears, bin reads and idle commands to histogram_3d_binner
// under several axis setups. A private copy of the bin store, the totals and
// the axis setup predicts each result word. Every returned word is compared
// field by field, in order, with the oldest prediction. Sender gaps and
// receiver stalls are random.
// ----------------------------------------------------------------------------
module histogram_3d_binner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import h3b_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;
    localparam int CYCLE_LIMIT = 2500000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  rx;
        logic [4:0]  ry;
        logic [4:0]  rz;
    } point_word_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] bin_value;
        logic [31:0] binned_total;
        logic [31:0] missed_total;
    } bin_report_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = CFG_X_MIN;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = CMD_BIN;
    logic signed [31:0] s_x_coord = '0;
    logic signed [31:0] s_y_coord = '0;
    logic signed [31:0] s_z_coord = '0;
    logic [4:0]         s_read_x_index = '0;
    logic [4:0]         s_read_y_index = '0;
    logic [4:0]         s_read_z_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [31:0]        m_bin_value;
    logic [31:0]        m_binned_total;
    logic [31:0]        m_missed_total;

    // histogram copy and axis setup
    logic [31:0] bin_tally [STORE_DEPTH];
    logic [31:0] binned_sum;
    logic [31:0] missed_sum;
    logic [31:0] axis_lo [3];
    logic [30:0] axis_w [3];
    logic [17:0] bin_counts;

    bin_report_t pending_reports [$];
    bin_report_t head_report;

    int  mismatches = 0;
    int  reports_seen = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  clears_left = 6;
    int  rx_tick = 0;
    int  stall_period = 1;
    int  stall_len = 0;
    bit  no_idle = 1'b0;

    histogram_3d_binner u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_x_coord      (s_x_coord),
        .s_y_coord      (s_y_coord),
        .s_z_coord      (s_z_coord),
        .s_read_x_index (s_read_x_index),
        .s_read_y_index (s_read_y_index),
        .s_read_z_index (s_read_z_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bin_value    (m_bin_value),
        .m_binned_total (m_binned_total),
        .m_missed_total (m_missed_total)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("histogram_3d_binner: mismatch");
            $finish;
        end
    end

    // receiver: periodic stall pattern, with period and length re-chosen at random
    always @(posedge aclk) begin
        if (rx_tick % 256 == 0) begin
            stall_period = $urandom_range(1, 12);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
        end
        m_ready <= no_idle || (rx_tick % stall_period >= stall_len);
        rx_tick++;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("word %0d unexpected: status %0d value %0d binned %0d missed %0d",
                             reports_seen, m_status, m_bin_value, m_binned_total,
                             m_missed_total);
                end
            end else begin
                head_report = pending_reports.pop_front();
                if (m_status !== head_report.status
                    || m_bin_value !== head_report.bin_value
                    || m_binned_total !== head_report.binned_total
                    || m_missed_total !== head_report.missed_total) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 reports_seen, head_report.status, head_report.bin_value,
                                 head_report.binned_total, head_report.missed_total,
                                 m_status, m_bin_value, m_binned_total, m_missed_total);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void clear_histogram();
        foreach (bin_tally[i]) bin_tally[i] = '0;
        binned_sum = '0;
        missed_sum = '0;
    endfunction

    function automatic int axis_limit(input int axis);
        int cap;
        int n;
        cap = (axis == AXIS_X) ? MAX_X_BINS : (axis == AXIS_Y) ? MAX_Y_BINS : MAX_Z_BINS;
        n = int'(bin_counts[6 * axis +: 6]);
        return (n > cap) ? cap : n;
    endfunction

    // floor((coord - min) / width) on a 33-bit difference; -1 when outside
    function automatic int axis_bin(input logic [31:0] coord, input int axis);
        longint diff;
        longint unsigned q;
        diff = longint'($signed(coord)) - longint'($signed(axis_lo[axis]));
        if (diff < 0 || axis_w[axis] == '0) return -1;
        q = longint'(diff) / longint'({1'b0, axis_w[axis]});
        if (q >= longint'(axis_limit(axis))) return -1;
        return int'(q);
    endfunction

    function automatic bin_report_t histogram_step(input point_word_t w);
        bin_report_t r;
        int xi;
        int yi;
        int zi;
        int a;
        r.status = STAT_DONE;
        r.bin_value = '0;
        case (w.cmd)
            CMD_BIN: begin
                xi = axis_bin(w.x, AXIS_X);
                yi = axis_bin(w.y, AXIS_Y);
                zi = axis_bin(w.z, AXIS_Z);
                if (xi >= 0 && yi >= 0 && zi >= 0) begin
                    a = (xi * MAX_Y_BINS + yi) * MAX_Z_BINS + zi;
                    bin_tally[a] = sat_bump(bin_tally[a]);
                    r.bin_value = bin_tally[a];
                    binned_sum = sat_bump(binned_sum);
                    r.status = STAT_BINNED;
                end else begin
                    missed_sum = sat_bump(missed_sum);
                    r.status = STAT_MISSED;
                end
            end
            CMD_CLEAR: clear_histogram();
            CMD_READ: begin
                a = (int'(w.rx) * MAX_Y_BINS + int'(w.ry)) * MAX_Z_BINS + int'(w.rz);
                r.bin_value = bin_tally[a];
            end
            default: ;
        endcase
        r.binned_total = binned_sum;
        r.missed_total = missed_sum;
        return r;
    endfunction

    task automatic send_word(input point_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_cmd <= w.cmd;
        s_x_coord <= w.x;
        s_y_coord <= w.y;
        s_z_coord <= w.z;
        s_read_x_index <= w.rx;
        s_read_y_index <= w.ry;
        s_read_z_index <= w.rz;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        pending_reports.push_back(histogram_step(w));
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        send_word('{CMD_BIN, x, y, z, 5'($urandom()), 5'($urandom()), 5'($urandom())});
    endtask

    task automatic send_read(input logic [4:0] rx, input logic [4:0] ry,
                             input logic [4:0] rz);
        send_word('{CMD_READ, $urandom(), $urandom(), $urandom(), rx, ry, rz});
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        send_word('{cmd, $urandom(), $urandom(), $urandom(),
                    5'($urandom()), 5'($urandom()), 5'($urandom())});
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    // leaves cfg_valid high so back-to-back writes keep one assignment per step
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_X_MIN:      axis_lo[AXIS_X] = data;
            CFG_Y_MIN:      axis_lo[AXIS_Y] = data;
            CFG_Z_MIN:      axis_lo[AXIS_Z] = data;
            CFG_X_WIDTH:    axis_w[AXIS_X] = data[30:0];
            CFG_Y_WIDTH:    axis_w[AXIS_Y] = data[30:0];
            CFG_Z_WIDTH:    axis_w[AXIS_Z] = data[30:0];
            CFG_BIN_COUNTS: bin_counts = data[17:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] xlo, input logic [31:0] ylo,
                             input logic [31:0] zlo, input logic [30:0] xw,
                             input logic [30:0] yw, input logic [30:0] zw,
                             input logic [17:0] counts);
        write_reg(CFG_X_MIN, xlo);
        write_reg(CFG_Y_MIN, ylo);
        write_reg(CFG_Z_MIN, zlo);
        write_reg(CFG_X_WIDTH, {1'b0, xw});
        write_reg(CFG_Y_WIDTH, {1'b0, yw});
        write_reg(CFG_Z_WIDTH, {1'b0, zw});
        write_reg(CFG_BIN_COUNTS, {14'd0, counts});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_lo();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return $urandom();
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_w();
        case ($urandom_range(0, 19))
            0: return '0;
            1, 2: return 31'($urandom_range(1, 32'h7FFF_FFFF));
            3, 4, 5: return 31'($urandom_range(1, 64));
            default: return 31'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    function automatic logic [5:0] rand_count();
        return ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 6));
    endfunction

    // mostly inside the axis range, with bin edges and noise mixed in
    function automatic logic [31:0] coord_near(input int axis);
        longint lo;
        longint w;
        longint c;
        int n;
        int idx;
        lo = longint'($signed(axis_lo[axis]));
        w = longint'({1'b0, axis_w[axis]});
        n = axis_limit(axis);
        idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
        case ($urandom_range(0, 11))
            0: return $urandom();
            1: c = lo - longint'($urandom_range(1, 3));
            2: c = lo + longint'(n) * w;
            3: c = lo + longint'(idx) * w;
            4: c = lo + longint'(idx) * w + w - 1;
            default: c = lo + longint'(idx) * w
                         + ((w == 0) ? 0 : longint'($urandom_range(0, 32'(w - 1))));
        endcase
        return c[31:0];
    endfunction

    function automatic logic [4:0] read_pick(input int axis);
        int n;
        n = axis_limit(axis);
        if ($urandom_range(0, 3) == 0 || n >= 32) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, n));
    endfunction

    function automatic point_word_t random_word();
        point_word_t w;
        int pick;
        pick = $urandom_range(0, 199);
        w.x = coord_near(AXIS_X);
        w.y = coord_near(AXIS_Y);
        w.z = coord_near(AXIS_Z);
        w.rx = read_pick(AXIS_X);
        w.ry = read_pick(AXIS_Y);
        w.rz = read_pick(AXIS_Z);
        if (pick == 0 && clears_left > 0) begin
            w.cmd = CMD_CLEAR;
            clears_left--;
        end else if (pick < 4) begin
            w.cmd = CMD_NONE;
        end else if (pick < 60) begin
            w.cmd = CMD_READ;
        end else begin
            w.cmd = CMD_BIN;
        end
        return w;
    endfunction

    task automatic test_reset_defaults();
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h001F_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h0020_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_read(5'd0, 5'd0, 5'd0);
        send_read(5'd31, 5'd0, 5'd0);
        send_cmd(CMD_NONE);
        send_cmd(CMD_CLEAR);
        send_read(5'd0, 5'd0, 5'd0);
    endtask

    // full-scale minimums and widths, x count above the bin limit
    task automatic test_extreme_setup();
        wait_idle();
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                  31'h7FFF_FFFF, 31'd1, 31'd65536, {6'd32, 6'd1, 6'd63});
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFE, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFE_FFFF);
        send_read(5'd2, 5'd0, 5'd1);
        send_read(5'd31, 5'd31, 5'd31);
    endtask

    // zero width and zero count each block an axis; the store survives
    task automatic test_empty_axes();
        wait_idle();
        configure('0, '0, '0, 31'd0, 31'd65536, 31'd65536, {6'd32, 6'd32, 6'd32});
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_read(5'd2, 5'd0, 5'd1);
        wait_idle();
        configure('0, '0, '0, 31'd65536, 31'd65536, 31'd65536, {6'd32, 6'd0, 6'd32});
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            no_idle = (ph == 3 || ph == 7);
            configure(rand_lo(), rand_lo(), rand_lo(), rand_w(), rand_w(), rand_w(),
                      {rand_count(), rand_count(), rand_count()});
            for (int k = 0; k < 140; k++) begin
                send_word(random_word());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        clear_histogram();
        foreach (axis_lo[i]) begin
            axis_lo[i] = '0;
            axis_w[i] = WIDTH_RST;
        end
        bin_counts = COUNTS_RST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_extreme_setup();
        test_empty_axes();
        test_random_traffic();

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("histogram_3d_binner: match");
        end else begin
            $display("histogram_3d_binner: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/h3b_pkg.sv
rtl/core/h3b_fifo.sv
rtl/core/h3b_front.sv
rtl/core/h3b_back.sv
rtl/core/histogram_3d_binner.sv
test/histogram_3d_binner_test.sv
